### rtl/assert_macros.svh
// Assertion macros for the RTL; they expand to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication or plain property checked on every rising clock edge outside reset.
`define MPV_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
// Condition that must never be true outside reset.
`define MPV_ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define MPV_ASSERT(label, clk, rstn, prop)
`define MPV_ASSERT_NEVER(label, clk, rstn, cond)
`endif
`endif

### rtl/mpv_pkg.sv
// Package with widths, pattern constants and codes for the magic packet validator.
`default_nettype none
package mpv_pkg;

    localparam int MAC_W   = 48;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 8;
    localparam int POS_W   = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;

    // Byte offsets inside the payload.
    localparam logic [CNT_W-1:0] HDR_LEN     = 8'd6;
    localparam logic [CNT_W-1:0] MAC_END     = 8'd12;
    localparam logic [CNT_W-1:0] PATTERN_LEN = 8'd102;
    localparam logic [CNT_W-1:0] FULL_LEN    = 8'd134;

    localparam logic [POS_W-1:0] MAC_LAST_POS = 3'd5;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_ENABLE = 2'd0,
        CFG_FILTER_MAC    = 2'd1,
        CFG_AUTH_REQUIRED = 2'd2
    } cfg_index_t;

    // Authentication status codes reported with each result.
    typedef enum logic [1:0] {
        AUTH_NONE  = 2'd0,
        AUTH_FAIL  = 2'd1,
        AUTH_CHECK = 2'd2
    } auth_status_t;

endpackage
`default_nettype wire

### rtl/magic_packet_validator.sv
// Top level of the magic packet validator: input stage, byte checker and result register.
`default_nettype none
// The validator takes a UDP payload one beat per byte, with s_last_byte set on the
// final byte, and returns exactly one result beat per packet. A payload is valid
// when it opens with six 0xFF bytes followed by sixteen copies of one MAC address;
// the first copy is captured and the fifteen others are compared against it, and
// with filtering enabled the captured address must also equal the configured MAC.
// Bytes after the 102-byte pattern are not checked; when authentication is required
// a valid packet of at least 134 bytes reports a status that asks for an external
// check of its tag, and a shorter one reports an authentication failure. The block
// sustains one byte per clock unless its input stalls: a byte is registered in the
// input register on acceptance, checked there by a single stage of compare logic,
// and the result of a final byte is loaded into the output register when that check
// completes. Input stalls only while a finished result waits in the output register
// and the next byte to be checked is itself a final byte.
// Configuration writes take effect at the next clock edge and are meant to be made
// while no packet is in flight; register indexes beyond the list are ignored.
module magic_packet_validator (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Configuration write port
    input  wire logic                          cfg_wr_en,
    input  wire logic [mpv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mpv_pkg::MAC_W-1:0]     cfg_wr_data,
    // Payload byte channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [mpv_pkg::BYTE_W-1:0]    s_data_byte,
    input  wire logic                          s_last_byte,
    // Result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_packet_valid,
    output logic [1:0]                         m_auth_status,
    output logic [mpv_pkg::MAC_W-1:0]          m_wake_mac
);
    import mpv_pkg::*;

    // Configuration registers.
    logic             filter_en_reg;
    logic [MAC_W-1:0] filter_mac_reg;
    logic             auth_req_reg;

    // Input stage.
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // Per-packet state.
    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [POS_W-1:0] mac_pos_reg, mac_pos_next;
    logic [MAC_W-1:0] captured_mac_reg, captured_mac_next;
    logic             pattern_ok_reg, pattern_ok_next;

    // Result register.
    logic             out_valid_reg;
    logic             out_pkt_valid_reg, out_pkt_valid_next;
    auth_status_t     out_auth_reg, out_auth_next;
    logic [MAC_W-1:0] out_mac_reg, out_mac_next;

    logic             stage_fire;
    logic             in_header, in_capture, in_compare;
    logic             byte_match;
    logic [BYTE_W-1:0] ref_byte;
    logic [CNT_W-1:0] len;
    logic             upd_pattern_ok;

    // A non-final byte never needs the result register, so it moves on even
    // while a result waits to be taken.
    assign stage_fire = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign s_ready    = !in_valid_reg || stage_fire;

    assign m_valid        = out_valid_reg;
    assign m_packet_valid = out_pkt_valid_reg;
    assign m_auth_status  = out_auth_reg;
    assign m_wake_mac     = out_mac_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_en_reg  <= 1'b0;
            filter_mac_reg <= '0;
            auth_req_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FILTER_ENABLE: filter_en_reg  <= cfg_wr_data[0];
                CFG_FILTER_MAC:    filter_mac_reg <= cfg_wr_data;
                CFG_AUTH_REQUIRED: auth_req_reg   <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // Input register: loaded whenever a byte is accepted.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
    end

    // Position of the byte in the packet decides which check applies.
    always_comb begin
        in_header  = byte_count_reg < HDR_LEN;
        in_capture = !in_header && (byte_count_reg < MAC_END);
        in_compare = (byte_count_reg >= MAC_END) && (byte_count_reg < PATTERN_LEN);
    end

    // Expected byte of the current MAC copy; unused positions count as a mismatch.
    always_comb begin
        ref_byte   = '0;
        byte_match = 1'b0;
        unique case (mac_pos_reg)
            3'd0: begin ref_byte = captured_mac_reg[47:40]; byte_match = 1'b1; end
            3'd1: begin ref_byte = captured_mac_reg[39:32]; byte_match = 1'b1; end
            3'd2: begin ref_byte = captured_mac_reg[31:24]; byte_match = 1'b1; end
            3'd3: begin ref_byte = captured_mac_reg[23:16]; byte_match = 1'b1; end
            3'd4: begin ref_byte = captured_mac_reg[15:8];  byte_match = 1'b1; end
            3'd5: begin ref_byte = captured_mac_reg[7:0];   byte_match = 1'b1; end
            default: begin ref_byte = '0; byte_match = 1'b0; end
        endcase
        byte_match = byte_match && (ref_byte == in_byte_reg);
    end

    always_comb begin
        upd_pattern_ok = pattern_ok_reg;
        if (in_header && (in_byte_reg != SYNC_BYTE)) begin
            upd_pattern_ok = 1'b0;
        end else if (in_compare && !byte_match) begin
            upd_pattern_ok = 1'b0;
        end

        captured_mac_next = captured_mac_reg;
        if (in_capture) begin
            captured_mac_next = {captured_mac_reg[MAC_W-BYTE_W-1:0], in_byte_reg};
        end

        mac_pos_next = mac_pos_reg;
        if (in_capture || in_compare) begin
            mac_pos_next = (mac_pos_reg >= MAC_LAST_POS) ? '0 : mac_pos_reg + 3'd1;
        end

        len = (byte_count_reg < FULL_LEN) ? byte_count_reg + 8'd1 : byte_count_reg;

        // Result of this byte, used only when it closes the packet.
        out_pkt_valid_next = (len >= PATTERN_LEN) && upd_pattern_ok;
        if (filter_en_reg && (captured_mac_next != filter_mac_reg)) begin
            out_pkt_valid_next = 1'b0;
        end
        out_auth_next = AUTH_NONE;
        if (out_pkt_valid_next && auth_req_reg) begin
            out_auth_next = (len < FULL_LEN) ? AUTH_FAIL : AUTH_CHECK;
        end
        out_mac_next = (len >= MAC_END) ? captured_mac_next : '0;

        // A final byte returns the packet state to its cleared form.
        if (in_last_reg) begin
            byte_count_next   = '0;
            mac_pos_next      = '0;
            captured_mac_next = '0;
            pattern_ok_next   = 1'b1;
        end else begin
            byte_count_next   = len;
            pattern_ok_next   = upd_pattern_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg   <= '0;
            mac_pos_reg      <= '0;
            captured_mac_reg <= '0;
            pattern_ok_reg   <= 1'b1;
        end else if (stage_fire) begin
            byte_count_reg   <= byte_count_next;
            mac_pos_reg      <= mac_pos_next;
            captured_mac_reg <= captured_mac_next;
            pattern_ok_reg   <= pattern_ok_next;
        end
    end

    // Result register: filled by a final byte, emptied when the beat is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (stage_fire && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_fire && in_last_reg) begin
            out_pkt_valid_reg <= out_pkt_valid_next;
            out_auth_reg      <= out_auth_next;
            out_mac_reg       <= out_mac_next;
        end
    end

`include "assert_macros.svh"

    `MPV_ASSERT(a_last_fills_result, aclk, aresetn, stage_fire && in_last_reg |=> m_valid)
    `MPV_ASSERT(a_last_clears_count, aclk, aresetn, stage_fire && in_last_reg |=> byte_count_reg == '0)
    `MPV_ASSERT_NEVER(a_count_saturates, aclk, aresetn, byte_count_reg > FULL_LEN)
    `MPV_ASSERT_NEVER(a_pos_in_range, aclk, aresetn, mac_pos_reg > MAC_LAST_POS)
    `MPV_ASSERT_NEVER(a_invalid_no_auth, aclk, aresetn, m_valid && !m_packet_valid && m_auth_status != AUTH_NONE)

endmodule
`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the magic packet validator: random byte stream, config phases.
`timescale 1ns / 100ps

module testbench;

    import mpv_pkg::*;

    // Register index that the block must ignore.
    localparam logic [CFG_IDX_W-1:0] UNUSED_REG = 2'd3;
    // Receiver hold-off used once to fill the block and stall its input.
    localparam int LONG_HOLD_CYCLES = 400;
    // Cycles to let pass after the last result before touching the registers.
    localparam int SETTLE_CYCLES = 10;

    // One payload beat waiting to be offered to the block.
    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
    } payload_beat_t;

    // One predicted packet verdict.
    typedef struct {
        logic               packet_valid;
        auth_status_t       auth_status;
        logic [MAC_W-1:0]   wake_mac;
    } wol_verdict_t;

    // Clock, reset and block ports. Every input starts at a known value.
    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [MAC_W-1:0]     cfg_wr_data = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_data_byte = '0;
    logic                 s_last_byte = 1'b0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic                 m_packet_valid;
    logic [1:0]           m_auth_status;
    logic [MAC_W-1:0]     m_wake_mac;

    // Beats still to be offered, and verdicts still to arrive.
    payload_beat_t pending_beats[$];
    wol_verdict_t  expected_verdicts[$];

    // Our own copy of the configuration registers.
    logic             flt_en   = 1'b0;
    logic [MAC_W-1:0] flt_mac  = '0;
    logic             auth_req = 1'b0;

    // Our own copy of the per-packet state of the detector.
    logic [CNT_W-1:0] pkt_count    = '0;
    logic [POS_W-1:0] copy_pos     = '0;
    logic [MAC_W-1:0] mac_seen     = '0;
    logic             pattern_good = 1'b1;

    // Run control shared between the stimulus thread and the clocked processes.
    bit quiet_run       = 1'b0;
    bit long_hold_armed = 1'b0;
    int mismatch_count  = 0;

    // Sender and receiver private state.
    int send_gap   = 0;
    int recv_gap   = 0;
    int hold_left  = 0;
    bit hold_taken = 1'b0;

    magic_packet_validator i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_packet_valid (m_packet_valid),
        .m_auth_status  (m_auth_status),
        .m_wake_mac     (m_wake_mac)
    );

    // 4 ns clock: two ns high, two ns low.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Advance the detector model by one accepted byte. On a final byte the verdict
    // for the packet is queued and the packet state returns to its reset values.
    function automatic void judge_byte(input logic [BYTE_W-1:0] b, input logic last);
        logic [CNT_W-1:0]  pos;
        logic [BYTE_W-1:0] copy_byte;
        wol_verdict_t      verdict;
        pos = pkt_count;
        if (pos < HDR_LEN) begin
            // The header must be six sync bytes.
            if (b != SYNC_BYTE) pattern_good = 1'b0;
        end else if (pos < MAC_END) begin
            // The first copy of the address is shifted in, first byte ending on top.
            mac_seen = {mac_seen[MAC_W-BYTE_W-1:0], b};
        end else if (pos < PATTERN_LEN) begin
            // The fifteen further copies are compared against the captured one.
            if (copy_pos <= MAC_LAST_POS) begin
                copy_byte = BYTE_W'(mac_seen >> (8 * (5 - int'(copy_pos))));
                if (copy_byte != b) pattern_good = 1'b0;
            end else begin
                pattern_good = 1'b0;
            end
        end
        if (pos >= HDR_LEN && pos < PATTERN_LEN) begin
            copy_pos = (copy_pos >= MAC_LAST_POS) ? '0 : copy_pos + 1'b1;
        end
        // Length saturates once a full tag is known to be present.
        if (pkt_count < FULL_LEN) pkt_count = pkt_count + 1'b1;
        if (last) begin
            verdict.packet_valid = (pkt_count >= PATTERN_LEN) && pattern_good;
            if (flt_en && mac_seen != flt_mac) verdict.packet_valid = 1'b0;
            verdict.auth_status = AUTH_NONE;
            if (verdict.packet_valid && auth_req) begin
                verdict.auth_status = (pkt_count < FULL_LEN) ? AUTH_FAIL : AUTH_CHECK;
            end
            // A packet too short to hold the first copy reports a zero address.
            verdict.wake_mac = (pkt_count >= MAC_END) ? mac_seen : '0;
            expected_verdicts.push_back(verdict);
            pkt_count    = '0;
            copy_pos     = '0;
            mac_seen     = '0;
            pattern_good = 1'b1;
        end
    endfunction

    // Compare one result beat with the oldest verdict still waiting.
    function automatic void check_verdict();
        wol_verdict_t want;
        if (expected_verdicts.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("%0t: unexpected result beat: valid=%0b auth=%0d mac=%012h",
                         $time, m_packet_valid, m_auth_status, m_wake_mac);
            end
        end else begin
            want = expected_verdicts.pop_front();
            if (m_packet_valid !== want.packet_valid || m_auth_status !== want.auth_status
                    || m_wake_mac !== want.wake_mac) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("%0t: result mismatch: expected valid=%0b auth=%0d mac=%012h",
                             $time, want.packet_valid, want.auth_status, want.wake_mac);
                    $display("%0t:                  actual valid=%0b auth=%0d mac=%012h",
                             $time, m_packet_valid, m_auth_status, m_wake_mac);
                end
            end
        end
    endfunction

    // Sender. A beat counts as accepted at an edge where valid and ready are both
    // high; only then is the model advanced. The next beat (or a gap) is chosen then or
    // while none is offered. While a beat is held, valid and payload stay as they are.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap = 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) judge_byte(s_data_byte, s_last_byte);
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_beats.size() == 0) begin
                s_valid <= 1'b0;
            end else if (!quiet_run && $urandom_range(0, 9) == 0) begin
                // Start an idle burst that begins at this edge.
                send_gap = $urandom_range(1, 6) - 1;
                s_valid  <= 1'b0;
            end else begin
                s_data_byte <= pending_beats[0].data;
                s_last_byte <= pending_beats[0].last;
                s_valid     <= 1'b1;
                void'(pending_beats.pop_front());
            end
        end
    end

    // Receiver. Checks each accepted result beat, stalls in random bursts, and once
    // holds off for a long stretch so that the block fills up and stalls its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            recv_gap   = 0;
            hold_left  = 0;
            hold_taken = 1'b0;
        end else begin
            if (m_valid && m_ready) check_verdict();
            if (long_hold_armed && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else if (!quiet_run && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(1, 6) - 1;
                m_ready  <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Write one configuration register while the block is idle, and mirror the
    // write in our own copy. Indexes beyond the list leave everything unchanged.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MAC_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        case (idx)
            CFG_FILTER_ENABLE: flt_en   = value[0];
            CFG_FILTER_MAC:    flt_mac  = value;
            CFG_AUTH_REQUIRED: auth_req = value[0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Write all three registers, plus a stray write to the unused index.
    task automatic set_config(input logic fe, input logic [MAC_W-1:0] mac, input logic ar);
        write_reg(CFG_FILTER_ENABLE, {{(MAC_W-1){1'b1}}, fe});
        write_reg(CFG_FILTER_MAC, mac);
        write_reg(CFG_AUTH_REQUIRED, MAC_W'({$urandom, $urandom}) & ~48'd1 | {47'd0, ar});
        write_reg(UNUSED_REG, {16'($urandom), 32'($urandom)});
    endtask

    // Queue a magic packet of the given length for the given address. Bytes past the
    // pattern are random tag bytes. A byte index of flip_at >= 0 gets corrupted.
    task automatic add_magic(input logic [MAC_W-1:0] mac, input int len, input int flip_at);
        payload_beat_t beat;
        for (int i = 0; i < len; i++) begin
            if (i < HDR_LEN) beat.data = SYNC_BYTE;
            else if (i < PATTERN_LEN) beat.data = BYTE_W'(mac >> (8 * (5 - (i - 6) % 6)));
            else beat.data = BYTE_W'($urandom);
            if (i == flip_at) beat.data ^= BYTE_W'($urandom_range(1, 255));
            beat.last = (i == len - 1);
            pending_beats.push_back(beat);
        end
    endtask

    // Queue a packet of random bytes, optionally opened by a proper sync header.
    task automatic add_noise(input int len, input bit sync_head);
        payload_beat_t beat;
        for (int i = 0; i < len; i++) begin
            beat.data = (sync_head && i < HDR_LEN) ? SYNC_BYTE : BYTE_W'($urandom);
            beat.last = (i == len - 1);
            pending_beats.push_back(beat);
        end
    endtask

    function automatic logic [MAC_W-1:0] random_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Random traffic: mostly well-formed magic packets with random lengths, carrying
    // the filter address or a random one; the rest corrupted, truncated or plain noise packets.
    task automatic random_traffic(input int min_beats, input int min_packets);
        int beats_start;
        int packets;
        int pick;
        int len;
        logic [MAC_W-1:0] mac;
        beats_start = pending_beats.size();
        packets = 0;
        while (pending_beats.size() - beats_start < min_beats || packets < min_packets) begin
            pick = $urandom_range(0, 99);
            mac  = $urandom_range(0, 1) ? flt_mac : random_mac();
            len  = $urandom_range(0, 3) == 0 ? 133 + $urandom_range(0, 2)
                                              : PATTERN_LEN + $urandom_range(0, 38);
            if ($urandom_range(0, 9) == 0) len = $urandom_range(141, 300);
            if (pick < 55) add_magic(mac, len, -1);
            else if (pick < 70) add_magic(mac, len, $urandom_range(0, PATTERN_LEN - 1));
            else if (pick < 80) add_magic(mac, $urandom_range(1, PATTERN_LEN - 1), -1);
            else add_noise($urandom_range(1, 24), $urandom_range(0, 1));
            packets++;
        end
    endtask

    // Wait until every beat has been offered and accepted and every verdict has
    // arrived, then wait out the settle time so that the pipeline can drain.
    task automatic wait_idle();
        @(negedge aclk);
        while (pending_beats.size() != 0 || s_valid || expected_verdicts.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Main stimulus thread.
    initial begin
        logic [MAC_W-1:0] mac;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset values written explicitly once, with a stray write to the unused index.
        set_config(1'b0, '0, 1'b0);

        // Directed packets with no filter and no authentication. These cover the
        // shortest packet, a capture one byte too short to report an address, one just
        // long enough, a bare pattern, one byte short of it and a corrupted pattern byte.
        mac = random_mac();
        add_noise(1, 1'b1);
        add_magic(mac, 11, -1);
        add_magic(mac, 12, -1);
        add_magic(mac, PATTERN_LEN, -1);
        add_magic(mac, PATTERN_LEN - 1, -1);
        add_magic(mac, PATTERN_LEN, $urandom_range(0, PATTERN_LEN - 1));
        random_traffic(60, 1);
        wait_idle();

        // Filter on a random address: a match passes, a one-bit difference fails.
        mac = random_mac();
        set_config(1'b1, mac, 1'b0);
        add_magic(mac, PATTERN_LEN, -1);
        add_magic(mac ^ (48'd1 << $urandom_range(0, MAC_W - 1)), PATTERN_LEN, -1);
        wait_idle();

        // Authentication required with a filter on the all-ones address, so that a
        // packet of nothing but sync bytes is a valid magic packet. One byte short of
        // the tag fails, a complete tag asks for the external check, a packet long
        // enough to wrap an unsaturated count does too, and an invalid packet reports
        // no authentication at all.
        set_config(1'b1, '1, 1'b1);
        add_magic('1, FULL_LEN - 1, -1);
        add_magic('1, FULL_LEN, -1);
        add_magic('1, 260, -1);
        add_magic('1, PATTERN_LEN, 50);
        wait_idle();

        // Long receiver hold-off while a stream of tiny packets keeps coming, so the
        // output register fills and the input must stall.
        long_hold_armed = 1'b1;
        for (int i = 0; i < 30; i++) add_noise($urandom_range(1, 3), 1'b0);
        wait_idle();

        // Final phase runs without any idling on either side.
        set_config(1'b1, '0, 1'b0);
        quiet_run = 1'b1;
        add_magic('0, PATTERN_LEN, -1);
        wait_idle();

        // Any verdict still waiting here was never delivered.
        mismatch_count += expected_verdicts.size();
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

endmodule
